// ===== hdl/line_rasterizer_2x_top_macros.svh =====
// ----------------------------------------------------------------------------
// line_rasterizer_2x_top_macros
// assertion macros used by the line rasterizer controller
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_2X_TOP_MACROS_SVH
`define LINE_RASTERIZER_2X_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define LR2X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define LR2X_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LR2X_ASSERT(lbl, prop, msg)
`define LR2X_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/lr2x_pkg.sv =====
// ----------------------------------------------------------------------------
// lr2x_pkg
// types and constants of the 2x line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package lr2x_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRACTION_BITS = 16;
  localparam int POS_BITS      = COORD_BITS + 1;
  localparam int ADDR_BITS     = 23;
  localparam int PIXEL_BITS    = 16;
  localparam int GRAY_IN_BITS  = 8;
  localparam int GRAY_BITS     = 5;
  localparam int PITCH_BITS    = 13;
  localparam int WIDTH_BITS    = 13;
  localparam int HEIGHT_BITS   = 12;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam int DIV_STEPS     = FRACTION_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int BEAT_BITS     = 2;

  localparam logic [PITCH_BITS-1:0]  PITCH_RST  = PITCH_BITS'(640);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = HEIGHT_BITS'(480);

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [BEAT_BITS-1:0] BEAT_LAST = 2'd3;

  typedef enum logic [2:0] {
    MODE_HORZ,
    MODE_VERT,
    MODE_DIAG,
    MODE_YMAJ,
    MODE_XMAJ
  } mode_t;

  typedef struct packed {
    logic                          req_type;
    logic signed [COORD_BITS-1:0]  x_begin;
    logic signed [COORD_BITS-1:0]  y_begin;
    logic signed [COORD_BITS-1:0]  x_finish;
    logic signed [COORD_BITS-1:0]  y_finish;
    logic [GRAY_IN_BITS-1:0]       gray_level;
  } in_word_t;

  typedef struct packed {
    logic                  write_enable;
    logic [ADDR_BITS-1:0]  word_address;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  last_of_point;
    logic                  line_done;
  } out_word_t;

  typedef struct packed {
    logic                 accept;
    logic                 div_step;
    logic                 mul_load;
    logic                 idle_word;
    logic [BEAT_BITS-1:0] beat;
  } ctl_cmd_t;

  typedef struct packed {
    logic line_active;
    logic div_needed;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lr2x_datapath.sv =====
// ----------------------------------------------------------------------------
// lr2x_datapath
// line state, serial slope divider, address multiplier and write formatting
// ----------------------------------------------------------------------------
`default_nettype none

module lr2x_datapath
  import lr2x_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ctl_cmd_t                 cmd,
  input  wire in_word_t                 in_data,
  input  wire logic                     cfg_wr,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output dp_status_t                    status,
  output out_word_t                     out_data
);

  logic [PITCH_BITS-1:0]  pitch_r;
  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;

  logic                         line_active_r;
  mode_t                        mode_r;
  logic signed [POS_BITS-1:0]   cur_x_r;
  logic signed [POS_BITS-1:0]   cur_y_r;
  logic signed [COORD_BITS-1:0] end_x_r;
  logic signed [COORD_BITS-1:0] end_y_r;
  logic                         x_neg_r;
  logic [FRACTION_BITS-1:0]     acc_r;
  logic [FRACTION_BITS-1:0]     inc_r;
  logic [POS_BITS-1:0]          remain_r;
  logic [GRAY_BITS-1:0]         gray_r;
  logic                         done_r;
  logic [COORD_BITS-1:0]        rem_r;
  logic [COORD_BITS-1:0]        divisor_r;
  logic [ADDR_BITS-2:0]         prod_r;

  // start decode
  logic signed [POS_BITS-1:0] ax, ay, bx, by;
  logic signed [POS_BITS-1:0] x0, y0, x1, y1;
  logic signed [POS_BITS-1:0] dx, dy;
  logic                       swap;
  logic [COORD_BITS-1:0]      adx, ady, major, minor;
  mode_t                      ld_mode;

  always_comb begin
    ax = {in_data.x_begin[COORD_BITS-1], in_data.x_begin};
    ay = {in_data.y_begin[COORD_BITS-1], in_data.y_begin};
    bx = {in_data.x_finish[COORD_BITS-1], in_data.x_finish};
    by = {in_data.y_finish[COORD_BITS-1], in_data.y_finish};
    swap = ay > by;
    x0 = swap ? bx : ax;
    y0 = swap ? by : ay;
    x1 = swap ? ax : bx;
    y1 = swap ? ay : by;
    dx = x1 - x0;
    dy = y1 - y0;
    adx = dx[POS_BITS-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS-1:0];
    major = (adx > ady) ? adx : ady;
    minor = (adx > ady) ? ady : adx;
    if (ady == '0) begin
      ld_mode = MODE_HORZ;
    end else if (adx == '0) begin
      ld_mode = MODE_VERT;
    end else if (adx == ady) begin
      ld_mode = MODE_DIAG;
    end else if (ady > adx) begin
      ld_mode = MODE_YMAJ;
    end else begin
      ld_mode = MODE_XMAJ;
    end
  end

  // advance step
  logic [POS_BITS-1:0]        remain_dec;
  logic                       adv_done;
  logic [FRACTION_BITS-1:0]   acc_sum;
  logic                       wrap;
  logic signed [POS_BITS-1:0] x_step;
  logic signed [POS_BITS-1:0] x_moved;
  logic signed [POS_BITS-1:0] y_moved;

  always_comb begin
    remain_dec = remain_r - POS_BITS'(1);
    adv_done   = remain_dec == '0;
    acc_sum    = acc_r + inc_r;
    wrap       = acc_sum <= acc_r;
    x_step     = x_neg_r ? '1 : POS_BITS'(1);
    x_moved    = cur_x_r + x_step;
    y_moved    = cur_y_r + POS_BITS'(1);
  end

  // divider step
  logic [COORD_BITS:0]   rem_dbl;
  logic [COORD_BITS:0]   rem_sub;
  logic                  quo_bit;

  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    quo_bit = rem_dbl >= {1'b0, divisor_r};
    rem_sub = quo_bit ? (rem_dbl - {1'b0, divisor_r}) : rem_dbl;
  end

  logic [PITCH_BITS+COORD_BITS-1:0] prod_full;
  assign prod_full = pitch_r * cur_y_r[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r       <= PITCH_RST;
      width_r       <= WIDTH_RST;
      height_r      <= HEIGHT_RST;
      line_active_r <= 1'b0;
      mode_r        <= MODE_HORZ;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      end_x_r       <= '0;
      end_y_r       <= '0;
      x_neg_r       <= 1'b0;
      acc_r         <= '0;
      inc_r         <= '0;
      remain_r      <= '0;
      gray_r        <= '0;
      done_r        <= 1'b1;
      rem_r         <= '0;
      divisor_r     <= '0;
      prod_r        <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_PITCH:  pitch_r  <= cfg_data[PITCH_BITS-1:0];
          CFG_WIDTH:  width_r  <= cfg_data[WIDTH_BITS-1:0];
          CFG_HEIGHT: height_r <= cfg_data[HEIGHT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (in_data.req_type == REQ_START) begin
          mode_r        <= ld_mode;
          cur_x_r       <= x0;
          cur_y_r       <= y0;
          end_x_r       <= x1[COORD_BITS-1:0];
          end_y_r       <= y1[COORD_BITS-1:0];
          x_neg_r       <= dx[POS_BITS-1];
          acc_r         <= '0;
          inc_r         <= '0;
          remain_r      <= {1'b0, major};
          gray_r        <= in_data.gray_level[GRAY_IN_BITS-1 -: GRAY_BITS];
          line_active_r <= major != '0;
          done_r        <= major == '0;
          rem_r         <= minor;
          divisor_r     <= major;
        end else if (line_active_r) begin
          remain_r      <= remain_dec;
          line_active_r <= !adv_done;
          done_r        <= adv_done;
          case (mode_r)
            MODE_HORZ: cur_x_r <= x_moved;
            MODE_VERT: cur_y_r <= y_moved;
            MODE_DIAG: begin
              cur_x_r <= x_moved;
              cur_y_r <= y_moved;
            end
            MODE_YMAJ, MODE_XMAJ: begin
              if (adv_done) begin
                cur_x_r <= {end_x_r[COORD_BITS-1], end_x_r};
                cur_y_r <= {end_y_r[COORD_BITS-1], end_y_r};
              end else begin
                acc_r <= acc_sum;
                if (mode_r == MODE_YMAJ) begin
                  if (wrap) cur_x_r <= x_moved;
                  cur_y_r <= y_moved;
                end else begin
                  if (wrap) cur_y_r <= y_moved;
                  cur_x_r <= x_moved;
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (cmd.div_step) begin
        rem_r <= rem_sub[COORD_BITS-1:0];
        inc_r <= {inc_r[FRACTION_BITS-2:0], quo_bit};
      end
      if (cmd.mul_load) begin
        prod_r <= prod_full[ADDR_BITS-2:0];
      end
    end
  end

  assign status.line_active = line_active_r;
  assign status.div_needed  = (mode_r == MODE_YMAJ) || (mode_r == MODE_XMAJ);

  // clip window and write formatting
  logic signed [WIDTH_BITS:0]    lim_x;
  logic signed [HEIGHT_BITS:0]   lim_y;
  logic signed [WIDTH_BITS:0]    cx_ext;
  logic                          visible;
  logic [ADDR_BITS-2:0]          base_sum;
  logic [ADDR_BITS-1:0]          beat_ofs;
  logic [ADDR_BITS-1:0]          addr;
  logic [PIXEL_BITS-1:0]         pixel;

  always_comb begin
    lim_x    = $signed({2'b00, width_r[WIDTH_BITS-1:1]} - (WIDTH_BITS+1)'(1));
    lim_y    = $signed({2'b00, height_r[HEIGHT_BITS-1:1]} - (HEIGHT_BITS+1)'(1));
    cx_ext   = {cur_x_r[POS_BITS-1], cur_x_r};
    visible  = !cur_x_r[POS_BITS-1] && !cur_y_r[POS_BITS-1] &&
               (cx_ext < lim_x) && (cur_y_r < lim_y);
    base_sum = prod_r + {{(ADDR_BITS-1-COORD_BITS){1'b0}}, cur_x_r[COORD_BITS-1:0]};
    beat_ofs = (cmd.beat[1] ? {{(ADDR_BITS-PITCH_BITS){1'b0}}, pitch_r} : '0) +
               {{(ADDR_BITS-1){1'b0}}, cmd.beat[0]};
    addr     = {base_sum, 1'b0} + beat_ofs;
    pixel    = {gray_r, gray_r, 1'b0, gray_r};
    if (cmd.idle_word) begin
      out_data.write_enable  = 1'b0;
      out_data.word_address  = '0;
      out_data.pixel_value   = '0;
      out_data.last_of_point = 1'b0;
      out_data.line_done     = 1'b1;
    end else begin
      out_data.write_enable  = visible;
      out_data.word_address  = visible ? addr : '0;
      out_data.pixel_value   = visible ? pixel : '0;
      out_data.last_of_point = cmd.beat == BEAT_LAST;
      out_data.line_done     = done_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lr2x_ctrl.sv =====
// ----------------------------------------------------------------------------
// lr2x_ctrl
// sequencer: accept, slope division, address multiply, four write beats
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_rasterizer_2x_top_macros.svh"

module lr2x_ctrl
  import lr2x_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_req_type,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_EMIT,
    S_NOLINE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [BEAT_BITS-1:0]    beat_r, beat_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = (state_r == S_EMIT) || (state_r == S_NOLINE);

  assign cmd.accept    = in_valid && in_ready;
  assign cmd.div_step  = (state_r == S_DIV) && status.div_needed;
  assign cmd.mul_load  = state_r == S_MUL;
  assign cmd.idle_word = state_r == S_NOLINE;
  assign cmd.beat      = beat_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    beat_nxt  = beat_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt  = '0;
        beat_nxt = '0;
        if (in_valid) begin
          if (in_req_type == REQ_START) begin
            state_nxt = S_DIV;
          end else if (status.line_active) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_NOLINE;
          end
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + DIV_CNT_BITS'(1);
        if (!status.div_needed || cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          beat_nxt = beat_r + BEAT_BITS'(1);
          if (beat_r == BEAT_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NOLINE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      beat_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      beat_r  <= beat_nxt;
    end
  end

  `LR2X_ASSERT(a_no_overlap, !(in_ready && out_valid), "input and output open together")
  `LR2X_ASSERT(a_last_beat_idle, (state_r == S_EMIT && out_ready && beat_r == BEAT_LAST) |=> in_ready, "no return to idle after last beat")
  `LR2X_ASSERT(a_div_length, (state_r == S_DIV && status.div_needed && cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) |=> (state_r == S_MUL), "divider overran")
  `LR2X_ASSERT(a_idle_advance, (in_valid && in_ready && in_req_type == REQ_ADVANCE && !status.line_active) |=> (state_r == S_NOLINE), "advance without line not answered")

endmodule

`default_nettype wire

// ===== hdl/line_rasterizer_2x_top.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_2x_top
// line rasterizer with 2x pixel doubling into an RGB565 framebuffer
// ----------------------------------------------------------------------------
// A start word loads a line (endpoints reordered top to bottom) and yields its
// first point; each advance word yields the next point. Every point leaves as
// four pixel words in order o, o+1, o+pitch, o+pitch+1. One word is handled at
// a time: an advance goes through accept, address multiply and four output
// beats, each with out_ready high. A start of a sloped line also runs the
// bit-serial slope divider, other starts skip the division. An advance with no
// line in progress answers with a single word in the next cycle. Configuration
// writes are always taken (cfg_ready is tied high) and should be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_2x_top
  import lr2x_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_word_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_word_t                     out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lr2x_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd)
  );

  lr2x_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
